// File: hw/rtl/sscf_pkg.sv
// ----------------------------------------------------------------------------
// sscf_pkg
// Shared types, codes and helper functions of the capture word CSV formatter.
// ----------------------------------------------------------------------------
package sscf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_OFFSET_A   = 3'd0;
    localparam logic [2:0] REG_GAIN_A     = 3'd1;
    localparam logic [2:0] REG_OFFSET_B   = 3'd2;
    localparam logic [2:0] REG_GAIN_B     = 3'd3;
    localparam logic [2:0] REG_POSITION_C = 3'd4;
    localparam logic [2:0] REG_POSITION_D = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [11:0] GAIN_UNITY = 12'd1024;

    // Text codes.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;

    // Byte slots of one row: four fields of four slots, then CR and LF.
    localparam logic [4:0] POS_FIRST = 5'd0;
    localparam logic [4:0] POS_CR    = 5'd16;
    localparam logic [4:0] POS_LF    = 5'd17;

    localparam int PAD_W = 9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic       cal_en;
        logic       load;
        logic [4:0] pos;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic skip;
        logic is_finish;
        logic fill_zero;
    } status_t;

    typedef struct packed {
        logic [1:0] h;
        logic [3:0] t;
        logic [3:0] u;
    } digits_t;

    // Splits a value of 0 to 255 into hundreds, tens and units.
    function automatic digits_t to_digits(input logic [7:0] v);
        digits_t     d;
        logic [7:0]  r8;
        logic [6:0]  r;
        logic [13:0] prod;
        logic [6:0]  ten_part;
        begin
            if (v >= 8'd200)
            begin
                d.h = 2'd2;
                r8  = v - 8'd200;
            end
            else if (v >= 8'd100)
            begin
                d.h = 2'd1;
                r8  = v - 8'd100;
            end
            else
            begin
                d.h = 2'd0;
                r8  = v;
            end
            r        = r8[6:0];
            // Multiplication by a reciprocal: exact for values below 100.
            prod     = {7'd0, r} * 14'd103;
            d.t      = prod[13:10];
            ten_part = {3'd0, d.t} * 7'd10;
            r        = r - ten_part;
            d.u      = r[3:0];
            return d;
        end
    endfunction

    // Rounds the scaled product, adds the offset and clamps the result.
    function automatic logic [7:0] calibrate(input logic [7:0] offset,
                                             input logic [19:0] prod);
        logic [20:0] rounded;
        logic [11:0] v;
        logic [7:0]  res;
        begin
            rounded = {1'b0, prod} + 21'd512;
            v       = {{4{offset[7]}}, offset} + {1'b0, rounded[20:10]};
            if (v[11] || (v == 12'd0))
            begin
                res = 8'd0;
            end
            else if ($signed(v) > 12'sd200)
            begin
                res = 8'd199;
            end
            else
            begin
                res = v[7:0];
            end
            return res;
        end
    endfunction

endpackage

// File: hw/rtl/scope_sample_csv_formatter_unit.sv
// ----------------------------------------------------------------------------
// scope_sample_csv_formatter_unit
// Turns oscilloscope capture words into CSV text, one text byte per output transfer.
// ----------------------------------------------------------------------------
// Each sample item is scaled, clamped and written as one CSV row of at most
// eighteen bytes: the two calibrated analog values, the two logic positions,
// each followed by a comma, then CR LF. An item is taken in idle, then passes
// through the gain multipliers and then the clamp and the decimal split. The
// row walk then steps through its eighteen byte slots (sixteen field slots
// plus CR and LF) in turn, whether the slot gives a byte or is a leading zero
// stepped over without one; an output stall holds the walk on a slot that
// gives a byte. The fixed row walk, not the multipliers, sets the rate. Only
// one item is in the block at a time; the next one is taken once the last
// byte of the row is in the output register. A finish item writes CR LF,
// reports on its final byte how many zero bytes pad the last sector and
// restarts the sector count; when the current sector is empty it writes
// nothing. The byte that completes a sector of SECTOR_BYTES bytes carries
// sector_full. Configuration writes are always taken and must only be made
// while the block is idle.
// ----------------------------------------------------------------------------
module scope_sample_csv_formatter_unit #(
    parameter int SECTOR_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sample_a[7:0], sample_b[15:8], logic_c[16],
                                       // logic_d[17], zero fill
    input  logic        s_axis_tuser,  // finish[0]
    // Output byte stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // text_byte[7:0], pad_zeros[16:8], zero fill
    output logic        m_axis_tuser,  // sector_full[0]
    output logic        m_axis_tlast
);

    sscf_pkg::cmd_t    cmd;
    sscf_pkg::status_t status;

    logic [7:0]                 text_byte;
    logic [sscf_pkg::PAD_W-1:0] pad_zeros;

    // Configuration is taken at once; writes must come only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    sscf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sscf_dp #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_a    (s_axis_tdata[7:0]),
        .sample_b    (s_axis_tdata[15:8]),
        .logic_c     (s_axis_tdata[16]),
        .logic_d     (s_axis_tdata[17]),
        .finish      (s_axis_tuser),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .text_byte   (text_byte),
        .sector_full (m_axis_tuser),
        .pad_zeros   (pad_zeros),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, pad_zeros, text_byte};

endmodule

// File: hw/rtl/sscf_ctrl.sv
// ----------------------------------------------------------------------------
// sscf_ctrl
// Sequencing state machine: accepts an item, steps the datapath through
// scaling and conversion, then walks the row's byte slots or a finish's CR LF.
// ----------------------------------------------------------------------------
module sscf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sscf_pkg::status_t status,
    output sscf_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_CAL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] pos_reg, pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= sscf_pkg::POS_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cmd.capture = 1'b0;
        cmd.mul_en  = 1'b0;
        cmd.cal_en  = 1'b0;
        cmd.load    = 1'b0;
        cmd.pos     = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (status.is_finish)
                begin
                    // An empty sector needs no closing line.
                    if (status.fill_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = sscf_pkg::POS_CR;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    pos_next   = sscf_pkg::POS_FIRST;
                    state_next = ST_CAL;
                end
            end
            ST_CAL:
            begin
                cmd.cal_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.skip)
                begin
                    pos_next = pos_reg + 5'd1;
                end
                else if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (pos_reg == sscf_pkg::POS_LF)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sscf_dp.sv
// ----------------------------------------------------------------------------
// sscf_dp
// Datapath: configuration registers, gain multipliers, clamp and decimal
// split, byte selection, sector count and the output register.
// ----------------------------------------------------------------------------
module sscf_dp #(
    parameter int SECTOR_BYTES = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [11:0]       cfg_data,
    input  logic [7:0]        sample_a,
    input  logic [7:0]        sample_b,
    input  logic              logic_c,
    input  logic              logic_d,
    input  logic              finish,
    input  sscf_pkg::cmd_t    cmd,
    output sscf_pkg::status_t status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        text_byte,
    output logic              sector_full,
    output logic [sscf_pkg::PAD_W-1:0] pad_zeros,
    output logic              last
);

    localparam int FILL_W = $clog2(SECTOR_BYTES);
    localparam int EXT_W  = (FILL_W + 1 > sscf_pkg::PAD_W) ? FILL_W + 1 : sscf_pkg::PAD_W;

    // Configuration.
    logic [7:0]  offset_a_reg, offset_b_reg, position_c_reg, position_d_reg;
    logic [11:0] gain_a_reg, gain_b_reg;

    // Captured item.
    logic [7:0]  sample_a_reg, sample_b_reg;
    logic        logic_c_reg, logic_d_reg, finish_reg;

    logic [19:0] prod_a_reg, prod_b_reg;

    logic [1:0]  hund_reg [4];
    logic [3:0]  tens_reg [4];
    logic [3:0]  unit_reg [4];

    logic [FILL_W-1:0] fill_reg, fill_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        full_reg, last_reg;
    logic [sscf_pkg::PAD_W-1:0] pad_reg;

    logic [7:0]        pos_c, pos_d;
    logic [7:0]        val [4];
    sscf_pkg::digits_t dig [4];
    logic [1:0]        field;
    logic [1:0]        slot;
    logic [7:0]        byte_sel;
    logic              skip_sel;
    logic [FILL_W:0]   fill_inc;
    logic              fill_wrap;
    logic              row_end;
    logic [EXT_W-1:0]  pad_full;
    logic [sscf_pkg::PAD_W-1:0] pad_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_a_reg   <= 8'd0;
            gain_a_reg     <= sscf_pkg::GAIN_UNITY;
            offset_b_reg   <= 8'd0;
            gain_b_reg     <= sscf_pkg::GAIN_UNITY;
            position_c_reg <= 8'd0;
            position_d_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sscf_pkg::REG_OFFSET_A:   offset_a_reg   <= cfg_data[7:0];
                sscf_pkg::REG_GAIN_A:     gain_a_reg     <= cfg_data;
                sscf_pkg::REG_OFFSET_B:   offset_b_reg   <= cfg_data[7:0];
                sscf_pkg::REG_GAIN_B:     gain_b_reg     <= cfg_data;
                sscf_pkg::REG_POSITION_C: position_c_reg <= cfg_data[7:0];
                sscf_pkg::REG_POSITION_D: position_d_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finish_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            finish_reg <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_a_reg <= sample_a;
            sample_b_reg <= sample_b;
            logic_c_reg  <= logic_c;
            logic_d_reg  <= logic_d;
        end
        if (cmd.mul_en)
        begin
            prod_a_reg <= {8'd0, gain_a_reg} * {12'd0, sample_a_reg};
            prod_b_reg <= {8'd0, gain_b_reg} * {12'd0, sample_b_reg};
        end
        if (cmd.cal_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hund_reg[i] <= dig[i].h;
                tens_reg[i] <= dig[i].t;
                unit_reg[i] <= dig[i].u;
            end
        end
    end

    assign pos_c  = logic_c_reg ? position_c_reg + 8'd20 : position_c_reg;
    assign pos_d  = logic_d_reg ? position_d_reg + 8'd20 : position_d_reg;
    assign val[0] = sscf_pkg::calibrate(offset_a_reg, prod_a_reg);
    assign val[1] = sscf_pkg::calibrate(offset_b_reg, prod_b_reg);
    assign val[2] = pos_c;
    assign val[3] = pos_d;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dig[i] = sscf_pkg::to_digits(val[i]);
        end
    end

    assign field = cmd.pos[3:2];
    assign slot  = cmd.pos[1:0];

    // Byte of the current slot, and whether it is a leading zero.
    always_comb
    begin
        skip_sel = 1'b0;
        byte_sel = sscf_pkg::ASCII_COMMA;
        if (cmd.pos == sscf_pkg::POS_CR)
        begin
            byte_sel = sscf_pkg::ASCII_CR;
        end
        else if (cmd.pos == sscf_pkg::POS_LF)
        begin
            byte_sel = sscf_pkg::ASCII_LF;
        end
        else
        begin
            case (slot)
                2'd0:
                begin
                    byte_sel = sscf_pkg::ASCII_ZERO + {6'd0, hund_reg[field]};
                    skip_sel = (hund_reg[field] == 2'd0);
                end
                2'd1:
                begin
                    byte_sel = sscf_pkg::ASCII_ZERO + {4'd0, tens_reg[field]};
                    skip_sel = (hund_reg[field] == 2'd0) && (tens_reg[field] == 4'd0);
                end
                2'd2:
                begin
                    byte_sel = sscf_pkg::ASCII_ZERO + {4'd0, unit_reg[field]};
                end
                default:
                begin
                    byte_sel = sscf_pkg::ASCII_COMMA;
                end
            endcase
        end
    end

    // Sector count.
    assign row_end   = (cmd.pos == sscf_pkg::POS_LF);
    assign fill_inc  = {1'b0, fill_reg} + {{FILL_W{1'b0}}, 1'b1};
    assign fill_wrap = (fill_inc == (FILL_W + 1)'(SECTOR_BYTES));
    assign pad_full  = EXT_W'(SECTOR_BYTES) - EXT_W'(fill_inc);

    always_comb
    begin
        pad_sel   = '0;
        fill_next = fill_reg;
        if (cmd.load)
        begin
            fill_next = fill_wrap ? '0 : fill_inc[FILL_W-1:0];
            if (finish_reg && row_end)
            begin
                // The closing line pads out and ends the current sector.
                fill_next = '0;
                if (!fill_wrap)
                begin
                    pad_sel = pad_full[sscf_pkg::PAD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Output register.
    assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= byte_sel;
            full_reg <= fill_wrap;
            pad_reg  <= pad_sel;
            last_reg <= row_end;
        end
    end

    assign status.skip      = skip_sel;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.is_finish = finish_reg;
    assign status.fill_zero = (fill_reg == '0);

    assign out_valid   = out_valid_reg;
    assign text_byte   = byte_reg;
    assign sector_full = full_reg;
    assign pad_zeros   = pad_reg;
    assign last        = last_reg;

endmodule

// File: hw/rtl/sscf_checker.sv
// ----------------------------------------------------------------------------
// sscf_checker
// Port-level checks of the CSV formatter, bound to the top level.
// ----------------------------------------------------------------------------
module sscf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled byte stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    // A stalled byte keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // A pad count is only reported on the final byte of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[16:8] != 9'd0) |-> m_axis_tlast)
        else $error("pad count on a byte that does not end the item");

    // No new item is taken while a row is still being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a row");

    // One item at a time: ready drops right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken straight after the first");

endmodule

bind scope_sample_csv_formatter_unit sscf_checker u_sscf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: dv/tb_scope_sample_csv_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scope_sample_csv_formatter_unit
// Self-checking bench for the capture word CSV formatter.
// ----------------------------------------------------------------------------
// Capture words are driven in from a queue and every text byte that leaves is
// compared with a byte predicted inside the bench. The prediction covers the
// calibration and clamp of both analog channels, the logic positions, the
// decimal text of each field, the sector count with its sector_full mark and
// the pad count reported by a finish. A directed part covers the field
// extremes, the clamp edges, zero values, position wrap, spare register
// indexes and finishes on empty sectors. The random part runs several
// calibrations and steers the stream so that a finish lands one and two bytes
// short of a sector boundary. Both sides idle in random bursts, the output
// side holds off once for a long stretch, and the last phase runs flat out.
// ----------------------------------------------------------------------------
module tb_scope_sample_csv_formatter_unit;

    localparam int SECTOR_BYTES = 512;

    // Calibration arithmetic.
    localparam int ROUND_HALF  = 512;
    localparam int GAIN_DIV    = 1024;
    localparam int CLAMP_LIMIT = 200;
    localparam int CLAMP_VALUE = 199;
    localparam logic [7:0] LOGIC_LIFT = 8'd20;

    // Register indexes that the block has no register behind.
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    // Row lengths: four commas plus CR LF always, one to three digits each.
    localparam int ROW_FIXED_BYTES = 6;
    localparam int ROW_MIN         = 10;
    localparam int ROW_MAX_UNITY   = 16;

    // Cycles to let pass once the last expected byte has arrived.
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 60;

    typedef struct packed {
        logic [7:0] sample_a;
        logic [7:0] sample_b;
        logic       logic_c;
        logic       logic_d;
        logic       finish;
    } capture_t;

    typedef struct packed {
        logic [7:0]  offset_a;
        logic [11:0] gain_a;
        logic [7:0]  offset_b;
        logic [11:0] gain_b;
        logic [7:0]  position_c;
        logic [7:0]  position_d;
    } calib_t;

    typedef struct packed {
        logic [7:0] text;
        logic       full;
        logic [8:0] pad;
        logic       last;
    } text_beat_t;

    typedef logic [7:0] text_q_t[$];

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [11:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // sample_a[7:0], sample_b[15:8], logic_c[16],
                                      // logic_d[17], zero fill
    logic        s_axis_tuser  = 1'b0; // finish[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // text_byte[7:0], pad_zeros[16:8], zero fill
    logic        m_axis_tuser;        // sector_full[0]
    logic        m_axis_tlast;

    // Calibration as the block holds it, and the byte count of the open sector.
    calib_t      cal;
    int          sector_fill_model;
    logic [15:0] sectors_closed;

    // Byte count of the open sector as the stimulus will leave it.
    int          plan_fill = 0;

    capture_t    capture_q[$];
    text_beat_t  text_expected[$];

    int          sent_count  = 0;
    int          taken_count = 0;
    int          errors      = 0;
    logic        in_fire     = 1'b0;
    logic        cfg_taken   = 1'b0;
    logic        traffic_gaps = 1'b1;
    int          tx_gap      = 0;
    int          rx_stall    = 0;
    logic        long_hold_done = 1'b0;
    capture_t    tx_item;
    capture_t    seen_item;
    text_beat_t  want;

    scope_sample_csv_formatter_unit #(
        .SECTOR_BYTES(SECTOR_BYTES)
    )
    dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Gain with rounding, then the signed offset, then the clamp. Note that
    // 200 is kept while anything above it becomes 199.
    function automatic int scaled(input logic [7:0] offset, input logic [11:0] gain,
                                  input logic [7:0] smp);
        int v;
        v = int'($signed(offset)) + (int'(gain) * int'(smp) + ROUND_HALF) / GAIN_DIV;
        if (v <= 0)
            return 0;
        if (v > CLAMP_LIMIT)
            return CLAMP_VALUE;
        return v;
    endfunction

    // The text of one row, without any sector bookkeeping.
    function automatic void row_text(input calib_t c, input capture_t s, output text_q_t row);
        int         vals[4];
        int         h;
        int         t;
        int         u;
        logic [7:0] pc;
        logic [7:0] pd;
        // The logic positions wrap within eight bits.
        pc      = c.position_c + (s.logic_c ? LOGIC_LIFT : 8'd0);
        pd      = c.position_d + (s.logic_d ? LOGIC_LIFT : 8'd0);
        vals[0] = scaled(c.offset_a, c.gain_a, s.sample_a);
        vals[1] = scaled(c.offset_b, c.gain_b, s.sample_b);
        vals[2] = int'(pc);
        vals[3] = int'(pd);
        row     = {};
        foreach (vals[i])
        begin
            h = vals[i] / 100;
            t = (vals[i] / 10) % 10;
            u = vals[i] % 10;
            // No leading zeros, but a zero value still gives one digit.
            if (h != 0)
                row.push_back(sscf_pkg::ASCII_ZERO + 8'(h));
            if (h != 0 || t != 0)
                row.push_back(sscf_pkg::ASCII_ZERO + 8'(t));
            row.push_back(sscf_pkg::ASCII_ZERO + 8'(u));
            row.push_back(sscf_pkg::ASCII_COMMA);
        end
        row.push_back(sscf_pkg::ASCII_CR);
        row.push_back(sscf_pkg::ASCII_LF);
    endfunction

    // Counts one byte into the open sector and says whether it closed it.
    function automatic logic count_byte();
        sector_fill_model++;
        if (sector_fill_model >= SECTOR_BYTES)
        begin
            sector_fill_model = 0;
            sectors_closed++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Queues the bytes that one accepted capture word must produce.
    function automatic void predict_text(input capture_t s);
        text_q_t    row;
        text_beat_t beat;
        int         pad;
        if (s.finish)
        begin
            // A finish on an empty sector writes nothing at all.
            if (sector_fill_model == 0)
                return;
            beat.text = sscf_pkg::ASCII_CR;
            beat.full = count_byte();
            beat.pad  = '0;
            beat.last = 1'b0;
            text_expected.push_back(beat);
            beat.text = sscf_pkg::ASCII_LF;
            beat.full = count_byte();
            // The pad is counted against the sector that holds the LF, and is
            // zero when the LF itself closed a sector.
            pad = 0;
            if (sector_fill_model != 0)
            begin
                pad               = SECTOR_BYTES - sector_fill_model;
                sector_fill_model = 0;
                sectors_closed++;
            end
            beat.pad  = pad[8:0];
            beat.last = 1'b1;
            text_expected.push_back(beat);
        end
        else
        begin
            row_text(cal, s, row);
            foreach (row[i])
            begin
                beat.text = row[i];
                beat.full = count_byte();
                beat.pad  = '0;
                beat.last = (i == row.size() - 1);
                text_expected.push_back(beat);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: registers, accepted capture words and outgoing text bytes are
    // all taken at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire   <= rst_n && s_axis_tvalid && s_axis_tready;
        cfg_taken <= rst_n && cfg_valid && cfg_ready;
        if (!rst_n)
        begin
            cal.offset_a      = '0;
            cal.gain_a        = sscf_pkg::GAIN_UNITY;
            cal.offset_b      = '0;
            cal.gain_b        = sscf_pkg::GAIN_UNITY;
            cal.position_c    = '0;
            cal.position_d    = '0;
            sector_fill_model = 0;
            sectors_closed    = '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (text_expected.size() == 0)
                begin
                    $error("text_byte: expected none, got %02h", m_axis_tdata[7:0]);
                    errors++;
                end
                else
                begin
                    want = text_expected.pop_front();
                    if (m_axis_tdata[7:0] !== want.text)
                    begin
                        $error("text_byte: expected %02h, got %02h", want.text,
                               m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.full)
                    begin
                        $error("sector_full: expected %0b, got %0b", want.full, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[16:8] !== want.pad)
                    begin
                        $error("pad_zeros: expected %0d, got %0d", want.pad,
                               m_axis_tdata[16:8]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sscf_pkg::REG_OFFSET_A:   cal.offset_a   = cfg_data[7:0];
                    sscf_pkg::REG_GAIN_A:     cal.gain_a     = cfg_data;
                    sscf_pkg::REG_OFFSET_B:   cal.offset_b   = cfg_data[7:0];
                    sscf_pkg::REG_GAIN_B:     cal.gain_b     = cfg_data;
                    sscf_pkg::REG_POSITION_C: cal.position_c = cfg_data[7:0];
                    sscf_pkg::REG_POSITION_D: cal.position_d = cfg_data[7:0];
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken_count++;
                seen_item.sample_a = s_axis_tdata[7:0];
                seen_item.sample_b = s_axis_tdata[15:8];
                seen_item.logic_c  = s_axis_tdata[16];
                seen_item.logic_d  = s_axis_tdata[17];
                seen_item.finish   = s_axis_tuser;
                predict_text(seen_item);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input driver: takes the next item from the queue once the current one
    // has been accepted, with random idle bursts in between.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (capture_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (traffic_gaps && $urandom_range(0, 5) == 0)
            begin
                tx_gap = $urandom_range(1, 18) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                tx_item = capture_q.pop_front();
                s_axis_tdata  <= {6'd0, tx_item.logic_d, tx_item.logic_c,
                                  tx_item.sample_b, tx_item.sample_a};
                s_axis_tuser  <= tx_item.finish;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off part way through so
    // that the block backs up and refuses input while the driver keeps going.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && taken_count >= LONG_HOLD_AFTER)
        begin
            long_hold_done = 1'b1;
            rx_stall       = LONG_HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (traffic_gaps && $urandom_range(0, 7) == 0)
        begin
            rx_stall = $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [2:0] index, input logic [11:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // The upper bits of the 8-bit registers carry junk that must be dropped.
    task automatic set_cal(input calib_t c);
        write_reg(sscf_pkg::REG_OFFSET_A,   {4'($urandom), c.offset_a});
        write_reg(sscf_pkg::REG_GAIN_A,     c.gain_a);
        write_reg(sscf_pkg::REG_OFFSET_B,   {4'($urandom), c.offset_b});
        write_reg(sscf_pkg::REG_GAIN_B,     c.gain_b);
        write_reg(sscf_pkg::REG_POSITION_C, {4'($urandom), c.position_c});
        write_reg(sscf_pkg::REG_POSITION_D, {4'($urandom), c.position_d});
    endtask

    // Waits until every accepted item has produced all its bytes, then lets
    // the block finish any finish that writes nothing.
    task automatic wait_idle();
        while (taken_count != sent_count || text_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send(input capture_t s);
        text_q_t row;
        capture_q.push_back(s);
        sent_count++;
        if (s.finish)
        begin
            plan_fill = 0;
        end
        else
        begin
            row_text(cal, s, row);
            plan_fill = (plan_fill + row.size()) % SECTOR_BYTES;
        end
    endtask

    function automatic capture_t sample_item(input logic [7:0] a, input logic [7:0] b,
                                             input logic lc, input logic ld);
        capture_t s;
        s.sample_a = a;
        s.sample_b = b;
        s.logic_c  = lc;
        s.logic_d  = ld;
        s.finish   = 1'b0;
        return s;
    endfunction

    // A finish carries random sample fields, which the block must ignore.
    function automatic capture_t finish_item();
        capture_t s;
        s        = $bits(capture_t)'($urandom);
        s.finish = 1'b1;
        return s;
    endfunction

    function automatic capture_t random_capture(input int finish_one_in);
        capture_t s;
        s        = $bits(capture_t)'($urandom);
        s.finish = ($urandom_range(1, finish_one_in) == 1);
        return s;
    endfunction

    function automatic calib_t random_calib();
        calib_t c;
        c = $bits(calib_t)'({$urandom, $urandom});
        return c;
    endfunction

    function automatic logic [7:0] sample_with_digits(input int n);
        case (n)
            1:       return 8'($urandom_range(0, 9));
            2:       return 8'($urandom_range(10, 99));
            default: return 8'($urandom_range(100, 255));
        endcase
    endfunction

    // Under unity calibration with zero positions a sample up to 200 is its own value
    // (above 200 it clamps to 199) and a logic bit gives 0 or 20, so a row of a chosen length can be built.
    function automatic capture_t capture_of_length(input int len);
        capture_t s;
        int       da;
        int       db;
        int       dc;
        int       dd;
        do
        begin
            da = $urandom_range(1, 3);
            db = $urandom_range(1, 3);
            dc = $urandom_range(1, 2);
            dd = $urandom_range(1, 2);
        end
        while (da + db + dc + dd + ROW_FIXED_BYTES != len);
        s = sample_item(sample_with_digits(da), sample_with_digits(db), dc == 2, dd == 2);
        return s;
    endfunction

    // Fills the open sector to short_by bytes below its end with rows of
    // random content, then sends a finish. Row lengths run from 10 to 16, so
    // the step sizes are chosen to never leave a gap that no row can close.
    task automatic run_to_sector_end(input int short_by);
        int r;
        int step;
        r = (2 * SECTOR_BYTES - short_by - plan_fill) % SECTOR_BYTES;
        if ((r > 0 && r < ROW_MIN) || (r > ROW_MAX_UNITY && r < 2 * ROW_MIN))
            r += SECTOR_BYTES;
        while (r > 0)
        begin
            if (r <= ROW_MAX_UNITY)
                step = r;
            else if (r <= 25 || (r >= 33 && r <= 35))
                step = ROW_MIN;
            else if (r <= 32)
                step = ROW_MAX_UNITY;
            else
                step = $urandom_range(ROW_MIN, ROW_MAX_UNITY);
            send(capture_of_length(step));
            r -= step;
        end
        send(finish_item());
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset calibration: a finish before any byte, zero values, clamp
        // edges, digit count edges, then a finish twice over.
        send(finish_item());
        send(sample_item(8'd0,   8'd0,   1'b0, 1'b0));
        send(sample_item(8'd255, 8'd255, 1'b1, 1'b1));
        send(sample_item(8'd200, 8'd201, 1'b0, 1'b1));
        send(sample_item(8'd199, 8'd9,   1'b1, 1'b0));
        send(sample_item(8'd10,  8'd99,  1'b0, 1'b0));
        send(sample_item(8'd100, 8'd1,   1'b1, 1'b1));
        send(finish_item());
        send(finish_item());
        wait_idle();

        // Most negative offset with full gain, most positive offset with no
        // gain, a position that wraps, and writes to the spare indexes.
        set_cal('{8'h80, 12'd4095, 8'h7F, 12'd0, 8'd235, 8'd250});
        write_reg(REG_SPARE_6, 12'($urandom));
        write_reg(REG_SPARE_7, 12'($urandom));
        send(sample_item(8'd0,   8'd0,   1'b0, 1'b0));
        send(sample_item(8'd255, 8'd255, 1'b1, 1'b1));
        // Gain and offset cancel exactly here, so the value is zero.
        send(sample_item(8'd32,  8'd0,   1'b1, 1'b0));
        // Just at 200, then just above it.
        send(sample_item(8'd82,  8'd17,  1'b0, 1'b1));
        send(sample_item(8'd83,  8'd200, 1'b1, 1'b1));
        send(finish_item());
        wait_idle();

        // Most positive offset with full gain, a gain too small to lift any
        // sample, and positions that wrap to small values.
        set_cal('{8'h7F, 12'd4095, 8'h00, 12'd1, 8'd255, 8'd236});
        send(sample_item(8'd255, 8'd255, 1'b1, 1'b1));
        send(sample_item(8'd0,   8'd128, 1'b0, 1'b0));
        send(finish_item());
        wait_idle();

        // Random calibrations with random words and the odd finish.
        repeat (2)
        begin
            set_cal(random_calib());
            repeat (13) send(random_capture(8));
            wait_idle();
        end

        // Unity calibration: steer the stream so that the finish lands one
        // byte short of a sector end (CR closes it, LF opens the next) and
        // then two bytes short (LF closes it and the pad is zero).
        set_cal('{8'd0, sscf_pkg::GAIN_UNITY, 8'd0, sscf_pkg::GAIN_UNITY, 8'd0, 8'd0});
        run_to_sector_end(1);
        run_to_sector_end(2);
        wait_idle();

        // Last stretch at full rate on both sides.
        traffic_gaps = 1'b0;
        set_cal(random_calib());
        repeat (24) send(random_capture(8));
        send(finish_item());
        wait_idle();

        if (errors == 0)
            $display("tb_scope_sample_csv_formatter_unit: done, clean");
        else
            $display("tb_scope_sample_csv_formatter_unit: done, errors");
        $finish;
    end

    // Watchdog for a block that hangs or drops bytes.
    initial
    begin
        #3_000_000;
        $display("tb_scope_sample_csv_formatter_unit: done, errors");
        $finish;
    end

endmodule
